>>> src/rmcf_pkg.sv
`default_nettype none

package rmcf_pkg;

   localparam int SENTENCE_BYTES_DEF = 64;
   localparam int SEARCH_WINDOW_DEF  = 20;
   localparam int SLOTS_DEF          = 8;

   localparam logic [2:0] HEADER_LEN    = 3'd6;
   localparam logic [1:0] STATUS_COMMAS = 2'd2;
   localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
   localparam logic [7:0] CHAR_COMMA    = 8'h2C;
   localparam logic [7:0] STATUS_RESET  = 8'h56;

   typedef enum logic [1:0] {
      MODE_SEARCH,
      MODE_PENDING,
      MODE_CAPTURE
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DRAIN,
      ST_BYTE,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic [2:0] slot;
      logic [5:0] byte_index;
      logic       last_of_sentence;
   } result_type;

   function automatic logic [7:0] header_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h24;
         3'd1:    c = 8'h47;
         3'd2:    c = 8'h50;
         3'd3:    c = 8'h52;
         3'd4:    c = 8'h4D;
         3'd5:    c = 8'h43;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> src/nmea_rmc_sentence_filter_top.sv
// Channel   Direction  Ports                       Content
// req       in         req_tvalid/tready/tdata/... one received byte, tlast = block end
// rsp       out        rsp_tvalid/tready/tdata/... one sentence byte or a not-found mark
// csr       in         csr_wen/csr_wdata           status byte that accepts a sentence
//
// An item passes IDLE, EVAL and FIN when it causes no sentence output, and BYTE as well when
// it carries one byte of a running capture or accepts a sentence; accepting one adds DRAIN:
// the held prefix drains from the prefix memory one byte per cycle, unless rsp stalls, through
// its single read port. Reset clears all control state; the prefix memory needs no clearing.
// A stalled rsp side holds the sequencer; req_tready is high only between items.
`default_nettype none

module nmea_rmc_sentence_filter_top #(
   parameter int SENTENCE_BYTES = rmcf_pkg::SENTENCE_BYTES_DEF,
   parameter int SEARCH_WINDOW  = rmcf_pkg::SEARCH_WINDOW_DEF,
   parameter int SLOTS          = rmcf_pkg::SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // in_byte[7:0]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // out_byte[7:0], slot[10:8], byte_index[16:11], zero
   output logic             rsp_tuser,   // kind
   output logic             rsp_tlast
);

   import rmcf_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       out_free;
   logic       emit_valid;
   result_type emit;

   rmcf_ctrl #(
      .SENTENCE_BYTES (SENTENCE_BYTES),
      .SEARCH_WINDOW  (SEARCH_WINDOW),
      .SLOTS          (SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_tvalid),
      .req_byte   (req_tdata),
      .req_end    (req_tlast),
      .req_ready  (req_tready),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit       (emit)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = emit_valid;
         rsp_in       = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.byte_index, rsp_ff.slot, rsp_ff.out_byte};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last_of_sentence;

endmodule

`default_nettype wire

>>> src/rmcf_prefix_ram.sv
`default_nettype none

module rmcf_prefix_ram #(
   parameter int  DEPTH = 20,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] prefix_mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prefix_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= prefix_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/rmcf_ctrl.sv
`default_nettype none

module rmcf_ctrl #(
   parameter int SENTENCE_BYTES = rmcf_pkg::SENTENCE_BYTES_DEF,
   parameter int SEARCH_WINDOW  = rmcf_pkg::SEARCH_WINDOW_DEF,
   parameter int SLOTS          = rmcf_pkg::SLOTS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wen,
   input  wire logic [7:0]          csr_wdata,
   input  wire logic                req_valid,
   input  wire logic [7:0]          req_byte,
   input  wire logic                req_end,
   output logic                     req_ready,
   input  wire logic                out_free,
   output logic                     emit_valid,
   output rmcf_pkg::result_type     emit
);

   import rmcf_pkg::*;

   localparam int AW = $clog2(SEARCH_WINDOW);
   localparam int LW = $clog2(SEARCH_WINDOW + 1);
   localparam int CW = $clog2(SENTENCE_BYTES);
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   logic [2:0]  hp_ff, hp_in;
   logic [1:0]  comma_ff, comma_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cap_ff, cap_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic        found_ff, found_in;
   logic [7:0]  stat_ff;
   logic [7:0]  byte_ff, byte_in;
   logic        end_ff, end_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    rd_data;
   logic          do_emit;
   logic [7:0]    emit_byte;
   logic          last_w;
   logic [LW-1:0] idx_nx;
   logic [CW+5:0] cap_ext;
   logic [SW+2:0] slot_ext;

   rmcf_prefix_ram #(
      .DEPTH (SEARCH_WINDOW)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (byte_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign last_w   = (cap_ff == CW'(SENTENCE_BYTES - 1));
   assign idx_nx   = idx_ff + 1'b1;
   assign cap_ext  = {6'd0, cap_ff};
   assign slot_ext = {3'd0, slot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= STATUS_RESET;
      end else if (csr_wen) begin
         stat_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_SEARCH;
         hp_ff    <= '0;
         comma_ff <= '0;
         len_ff   <= '0;
         idx_ff   <= '0;
         cap_ff   <= '0;
         slot_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         hp_ff    <= hp_in;
         comma_ff <= comma_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         cap_ff   <= cap_in;
         slot_ff  <= slot_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      hp_in      = hp_ff;
      comma_in   = comma_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      cap_in     = cap_ff;
      slot_in    = slot_ff;
      found_in   = found_ff;
      byte_in    = byte_ff;
      end_in     = end_ff;
      wr_en      = 1'b0;
      wr_addr    = len_ff[AW-1:0];
      rd_en      = 1'b0;
      rd_addr    = '0;
      req_ready  = 1'b0;
      do_emit    = 1'b0;
      emit_byte  = byte_ff;
      emit_valid = 1'b0;
      emit       = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               byte_in  = req_byte;
               end_in   = req_end;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_FIN;
            if (mode_ff == MODE_CAPTURE) begin
               state_in = ST_BYTE;
            end else if (mode_ff == MODE_PENDING) begin
               if (byte_ff == CHAR_DOLLAR) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  mode_in  = MODE_SEARCH;
                  len_in   = LW'(1);
                  hp_in    = 3'd1;
                  comma_in = '0;
               end else if (comma_ff >= STATUS_COMMAS) begin
                  if (byte_ff == stat_ff) begin
                     found_in = 1'b1;
                     mode_in  = MODE_CAPTURE;
                     cap_in   = '0;
                     idx_in   = '0;
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_DRAIN;
                  end else begin
                     mode_in = MODE_SEARCH;
                     hp_in   = '0;
                  end
               end else if (len_ff >= LW'(SEARCH_WINDOW)) begin
                  mode_in = MODE_SEARCH;
                  hp_in   = '0;
               end else begin
                  wr_en  = 1'b1;
                  len_in = len_ff + 1'b1;
                  if (byte_ff == CHAR_COMMA) begin
                     comma_in = comma_ff + 1'b1;
                  end
               end
            end else if (!found_ff) begin
               if (byte_ff == CHAR_DOLLAR) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  mode_in  = MODE_SEARCH;
                  len_in   = LW'(1);
                  hp_in    = 3'd1;
                  comma_in = '0;
               end else if (hp_ff != 3'd0 && hp_ff < HEADER_LEN
                            && len_ff < LW'(SEARCH_WINDOW)
                            && byte_ff == header_char(hp_ff)) begin
                  wr_en  = 1'b1;
                  len_in = len_ff + 1'b1;
                  if (hp_ff == HEADER_LEN - 3'd1) begin
                     mode_in  = MODE_PENDING;
                     hp_in    = '0;
                     comma_in = '0;
                  end else begin
                     hp_in = hp_ff + 3'd1;
                  end
               end else begin
                  hp_in = '0;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               do_emit   = 1'b1;
               emit_byte = rd_data;
               if (last_w) begin
                  state_in = ST_FIN;
               end else if (idx_nx >= len_ff) begin
                  state_in = ST_BYTE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_nx[AW-1:0];
                  idx_in  = idx_nx;
               end
            end
         end
         ST_BYTE: begin
            if (out_free) begin
               do_emit  = 1'b1;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (end_ff && !found_ff) begin
               if (out_free) begin
                  emit_valid            = 1'b1;
                  emit.kind             = 1'b1;
                  emit.last_of_sentence = 1'b1;
                  state_in              = ST_IDLE;
               end
            end else begin
               if (end_ff) begin
                  found_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_emit) begin
         emit_valid            = 1'b1;
         emit.kind             = 1'b0;
         emit.out_byte         = emit_byte;
         emit.slot             = slot_ext[2:0];
         emit.byte_index       = cap_ext[5:0];
         emit.last_of_sentence = last_w;
         cap_in                = cap_ff + 1'b1;
         if (last_w) begin
            cap_in  = '0;
            mode_in = MODE_SEARCH;
            hp_in   = '0;
            if (slot_ff == SW'(SLOTS - 1)) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire
